FILE: src/ncr_pkg.sv
// ----------------------------------------------------------------------------
// ncr_pkg: shared types and constants for the Newton cube root unit
// Register map, field widths, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ncr_pkg;

	// default build parameters
	localparam int IN_WIDTH_DEF   = 32;
	localparam int ROOT_FRAC_DEF  = 16;

	// fixed-point layout
	localparam int IN_FRAC_BITS   = 8;
	localparam int ROOT_INT_BITS  = 8;

	// register field widths
	localparam int GUESS_W        = 24;
	localparam int TOL_W          = 5;
	localparam int ITER_W         = 8;

	// register reset values
	localparam logic [GUESS_W-1:0] GUESS_RST = 24'd524288;
	localparam logic [TOL_W-1:0]   TOL_RST   = 5'd26;
	localparam logic [ITER_W-1:0]  ITER_RST  = 8'd64;

	// APB register map (word index)
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_GUESS    = 2'd0;
	localparam logic [1:0] REG_TOL      = 2'd1;
	localparam logic [1:0] REG_MAX_ITER = 2'd2;

	typedef struct packed {
		logic [GUESS_W-1:0] initial_guess;
		logic [TOL_W-1:0]   tol_shift;
		logic [ITER_W-1:0]  max_iter;
	} ncr_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_UPD,
		ST_FIN
	} ncr_state_t;

endpackage

`default_nettype wire

FILE: src/ncr_cfg.sv
// ----------------------------------------------------------------------------
// ncr_cfg: APB configuration registers
// Holds initial guess, tolerance shift and iteration cap; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ncr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output ncr_pkg::ncr_cfg_t                cfg
);
	import ncr_pkg::*;

	ncr_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_guess <= GUESS_RST;
			cfg_q.tol_shift     <= TOL_RST;
			cfg_q.max_iter      <= ITER_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GUESS:    cfg_q.initial_guess <= pwdata[GUESS_W-1:0];
				REG_TOL:      cfg_q.tol_shift     <= pwdata[TOL_W-1:0];
				REG_MAX_ITER: cfg_q.max_iter      <= pwdata[ITER_W-1:0];
				default: begin
					// unmapped address: drop the write
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GUESS:    prdata = {{(32-GUESS_W){1'b0}}, cfg_q.initial_guess};
			REG_TOL:      prdata = {{(32-TOL_W){1'b0}}, cfg_q.tol_shift};
			REG_MAX_ITER: prdata = {{(32-ITER_W){1'b0}}, cfg_q.max_iter};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/ncr_div.sv
// ----------------------------------------------------------------------------
// ncr_div: radix-2 restoring divider with saturating quotient
// Computes min(floor(v * 2^QSHIFT / d), 2 * root_max), one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_div #(
	parameter int IN_WIDTH       = ncr_pkg::IN_WIDTH_DEF,
	parameter int ROOT_FRAC_BITS = ncr_pkg::ROOT_FRAC_DEF
) (
	input  wire logic                                                 clk,
	input  wire logic                                                 arst_n,
	input  wire logic                                                 start,
	input  wire logic [IN_WIDTH-1:0]                                  dividend,
	input  wire logic [2*(ncr_pkg::ROOT_INT_BITS+ROOT_FRAC_BITS)-1:0] divisor,
	output logic      [ncr_pkg::ROOT_INT_BITS+ROOT_FRAC_BITS:0]       quot,
	output logic                                                      done
);
	import ncr_pkg::*;

	localparam int ROOT_BITS = ROOT_INT_BITS + ROOT_FRAC_BITS;
	localparam int QSHIFT    = 3 * ROOT_FRAC_BITS - IN_FRAC_BITS;
	localparam int NSTEP     = IN_WIDTH + QSHIFT;
	localparam int DW        = 2 * ROOT_BITS;
	localparam int QW        = ROOT_BITS + 1;
	localparam int CW        = $clog2(NSTEP);
	localparam logic [QW-1:0] CAP = {{ROOT_BITS{1'b1}}, 1'b0};

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [IN_WIDTH-1:0] sh_q;
	logic [DW-1:0]      d_q;
	logic [DW-1:0]      r_q;
	logic [QW-1:0]      q_q;

	logic [DW:0]        r2;
	logic [DW+1:0]      trial;
	logic               ge;
	logic [DW-1:0]      r_next;
	logic [QW:0]        qs;
	logic [QW-1:0]      q_next;

	// remainder stays below d, so one extra bit holds the shifted value
	assign r2     = {r_q, sh_q[IN_WIDTH-1]};
	assign trial  = {1'b0, r2} - {2'b00, d_q};
	assign ge     = ~trial[DW+1];
	assign r_next = ge ? trial[DW-1:0] : r2[DW-1:0];
	assign qs     = {q_q, ge};
	// hold the quotient at the cap once it passes it
	assign q_next = (qs > {1'b0, CAP}) ? CAP : qs[QW-1:0];

	assign quot = q_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NSTEP - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			d_q  <= divisor;
			r_q  <= '0;
			q_q  <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[IN_WIDTH-2:0], 1'b0};
			r_q  <= r_next;
			q_q  <= q_next;
		end
	end

endmodule

`default_nettype wire

FILE: src/newton_cube_root_unit.sv
// Sequencing: a zero input or a zero iteration cap goes straight to the output
//   register; otherwise each Newton step squares the guess, runs the bit-serial
//   divider and then updates the guess.
// Throughput: one item at a time; the next item is taken once the current
//   result is in the output register.
// Reset: arst_n clears the sequencer and output valid and restores defaults.
// ----------------------------------------------------------------------------
// newton_cube_root_unit: fixed-point cube root by damped Newton iteration
// Q24.8 in, Q8.16 out; shared squarer and divider under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module newton_cube_root_unit #(
	parameter int IN_WIDTH       = ncr_pkg::IN_WIDTH_DEF,
	parameter int ROOT_FRAC_BITS = ncr_pkg::ROOT_FRAC_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// value
	input  wire logic [((IN_WIDTH+7)/8)*8-1:0]       s_tdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// root, iterations, converged
	output logic [((ncr_pkg::ROOT_INT_BITS+ROOT_FRAC_BITS+9+7)/8)*8-1:0] m_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ncr_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [31:0]                         pwdata,
	output logic      [31:0]                         prdata,
	output logic                                     pready
);
	import ncr_pkg::*;

	localparam int ROOT_BITS = ROOT_INT_BITS + ROOT_FRAC_BITS;
	localparam int DW        = 2 * ROOT_BITS;
	localparam int QW        = ROOT_BITS + 1;
	localparam int OUT_W     = ROOT_BITS + ITER_W + 1;
	localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8;
	localparam int GEW       = (ROOT_BITS > GUESS_W) ? ROOT_BITS : GUESS_W;
	localparam logic [ROOT_BITS-1:0] ROOT_MAX = '1;
	localparam logic [ROOT_BITS-1:0] ROOT_ONE = ROOT_BITS'(1);

	ncr_cfg_t   cfg;
	ncr_state_t state_q, state_d;

	logic [IN_WIDTH-1:0]  v_q;
	logic [ROOT_BITS-1:0] g_q;
	logic [ITER_W-1:0]    it_q;
	logic                 conv_q;
	logic [DW-1:0]        sq_q;

	logic                 out_valid_q;
	logic [ROOT_BITS-1:0] out_root_q;
	logic [ITER_W-1:0]    out_it_q;
	logic                 out_conv_q;

	logic                 accept;
	logic                 div_start;
	logic                 div_done;
	logic [QW-1:0]        div_q;
	logic                 out_load;

	logic [GEW-1:0]       guess_ext;
	logic [ROOT_BITS-1:0] guess_sat;
	logic [IN_WIDTH-1:0]  in_value;

	logic [ROOT_BITS+1:0] sum;
	logic [ROOT_BITS:0]   half;
	logic [ROOT_BITS-1:0] ng_clip;
	logic [ROOT_BITS-1:0] ng;
	logic [ROOT_BITS-1:0] diff;
	logic [ROOT_BITS-1:0] lo;
	logic                 conv_now;
	logic [ITER_W-1:0]    it_next;

	ncr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ncr_div #(
		.IN_WIDTH       (IN_WIDTH),
		.ROOT_FRAC_BITS (ROOT_FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q),
		.divisor  (sq_q),
		.quot     (div_q),
		.done     (div_done)
	);

	assign in_value = s_tdata[IN_WIDTH-1:0];

	// starting guess: zero taken as one, clamp to the root range
	assign guess_ext = GEW'(cfg.initial_guess);
	always_comb begin
		if (guess_ext == '0)
			guess_sat = ROOT_ONE;
		else if (guess_ext > GEW'(ROOT_MAX))
			guess_sat = ROOT_MAX;
		else
			guess_sat = guess_ext[ROOT_BITS-1:0];
	end

	// update: average guess and quotient, saturate, never zero
	assign sum      = {2'b00, g_q} + {1'b0, div_q};
	assign half     = sum[ROOT_BITS+1:1];
	assign ng_clip  = half[ROOT_BITS] ? ROOT_MAX : half[ROOT_BITS-1:0];
	assign ng       = (ng_clip == '0) ? ROOT_ONE : ng_clip;
	assign diff     = (ng > g_q) ? (ng - g_q) : (g_q - ng);
	assign lo       = (ng < g_q) ? ng : g_q;
	// (diff << tol) <= lo is the same as diff <= lo >> tol
	assign conv_now = (diff <= (lo >> cfg.tol_shift));
	assign it_next  = it_q + 1'b1;

	assign accept = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_value == '0 || cfg.max_iter == '0)
						state_d = ST_FIN;
					else
						state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (div_done)
					state_d = ST_UPD;
			end
			ST_UPD: begin
				if (conv_now || it_next == cfg.max_iter)
					state_d = ST_FIN;
				else
					state_d = ST_MUL;
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q  <= in_value;
			it_q <= '0;
			if (in_value == '0) begin
				g_q    <= '0;
				conv_q <= 1'b1;
			end else begin
				g_q    <= guess_sat;
				conv_q <= 1'b0;
			end
		end else if (state_q == ST_MUL) begin
			sq_q <= DW'(g_q) * DW'(g_q);
		end else if (state_q == ST_UPD) begin
			g_q    <= ng;
			it_q   <= it_next;
			conv_q <= conv_now;
		end
	end

	// output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_root_q <= g_q;
			out_it_q   <= it_q;
			out_conv_q <= conv_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TW-OUT_W){1'b0}}, out_conv_q, out_it_q, out_root_q};

endmodule

`default_nettype wire

FILE: dv/newton_cube_root_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_cube_root_unit_tb: self-checking bench for the Newton cube root unit
// Streams Q24.8 values through the slave port under several register settings
// and idling mixes, predicts root, step count and convergence flag per item,
// and compares every result item in order against the prediction.
// ----------------------------------------------------------------------------

module newton_cube_root_unit_tb;
	import ncr_pkg::*;

	localparam int          LIMIT_CYCLES = 8_000_000;
	localparam int          TAIL_CYCLES  = 200;
	localparam logic [63:0] ROOT_MAX     = 64'hFF_FFFF;

	typedef struct packed {
		logic [23:0] root;
		logic [7:0]  iterations;
		logic        converged;
	} cube_root_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic [31:0] s_tdata  = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// register mirror
	logic [23:0] cfg_guess    = GUESS_RST;
	logic [4:0]  cfg_tol      = TOL_RST;
	logic [7:0]  cfg_max_iter = ITER_RST;

	logic [31:0] pending_values[$];
	cube_root_t  expected_roots[$];
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	newton_cube_root_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),   // value [31:0]
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),   // root [23:0], iterations [31:24], converged [32]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	function automatic cube_root_t predict_root(input logic [31:0] value);
		cube_root_t  res;
		logic [63:0] g;
		logic [63:0] q;
		logic [63:0] ng;
		logic [63:0] diff;
		logic [63:0] lo;
		logic [79:0] quot;
		int unsigned step;
		res.root       = '0;
		res.iterations = '0;
		res.converged  = 1'b0;
		if (value == 0) begin
			res.converged = 1'b1;
			return res;
		end
		g = {40'd0, cfg_guess};
		if (g == 0)
			g = 1;
		for (step = 1; step <= cfg_max_iter; step++) begin
			// quotient in root format, limited to twice the largest root
			quot = ({48'd0, value} << 40) / {16'd0, g * g};
			q = (quot > {16'd0, 2 * ROOT_MAX}) ? 2 * ROOT_MAX : quot[63:0];
			ng = (g + q) >> 1;
			if (ng > ROOT_MAX)
				ng = ROOT_MAX;
			if (ng == 0)
				ng = 1;
			diff = (ng > g) ? ng - g : g - ng;
			lo = (ng < g) ? ng : g;
			res.iterations = step[7:0];
			g = ng;
			if ((diff << cfg_tol) <= lo) begin
				res.converged = 1'b1;
				break;
			end
		end
		res.root = g[23:0];
		return res;
	endfunction

	function automatic logic [31:0] random_value();
		int unsigned sel;
		logic [63:0] t;
		sel = $urandom_range(99);
		if (sel < 40)
			return $urandom;
		if (sel < 65)
			return $urandom >> $urandom_range(31);
		if (sel < 85) begin
			// cube of a root with four fraction bits, truncated to eight fraction bits
			t = $urandom_range(1, 4095);
			return 32'((t * t * t) >> 4);
		end
		if (sel < 95)
			return $urandom_range(1, 1024);
		return ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_count < 50)
			$display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
		mismatch_count++;
	endtask

	// driver: predict on acceptance, then offer the next pending item
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_roots.push_back(predict_root(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_values.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result item with the oldest prediction
	always @(posedge clk) begin
		cube_root_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_roots.size() == 0) begin
					report_mismatch("unexpected result", {24'd0, m_tdata}, 64'd0);
				end else begin
					want = expected_roots.pop_front();
					if (m_tdata[23:0] !== want.root)
						report_mismatch("root", 64'(m_tdata[23:0]), 64'(want.root));
					if (m_tdata[31:24] !== want.iterations)
						report_mismatch("iterations", 64'(m_tdata[31:24]),
							64'(want.iterations));
					if (m_tdata[32] !== want.converged)
						report_mismatch("converged", 64'(m_tdata[32]),
							64'(want.converged));
					if (m_tdata[39:33] !== 7'd0)
						report_mismatch("padding", 64'(m_tdata[39:33]), 64'd0);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("newton_cube_root_unit verification failed");
			$finish;
		end
	end

	task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx)
			REG_GUESS:    cfg_guess = data[23:0];
			REG_TOL:      cfg_tol = data[4:0];
			REG_MAX_ITER: cfg_max_iter = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [23:0] guess, input logic [4:0] tol,
		input logic [7:0] max_iter);
		apb_write(REG_GUESS, {8'd0, guess});
		apb_write(REG_TOL, {27'd0, tol});
		apb_write(REG_MAX_ITER, {24'd0, max_iter});
	endtask

	// hold until every queued item has gone in and every result has come out
	task automatic wait_idle();
		while (pending_values.size() != 0 || s_tvalid || expected_roots.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int n_items, input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int k = 0; k < n_items; k++) begin
			pending_values.push_back(random_value());
			// drain halfway so the sender sits out a full pass
			if (k == n_items / 2)
				wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: field extremes and exact cubes
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pending_values.push_back(32'h0);
		pending_values.push_back(32'h1);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'h100);
		pending_values.push_back(32'h800);
		pending_values.push_back(32'd27 << 8);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'hAAAA_AAAA);
		pending_values.push_back(32'h5555_5555);
		pending_values.push_back(32'd125 << 8);
		wait_idle();

		// tolerance shift 30, longest cap, largest guess
		set_config(24'hFF_FFFF, 5'd30, 8'd255);
		pending_values.push_back(32'h1);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'd64 << 8);
		wait_idle();

		// tolerance shift 8, single step, smallest guess
		set_config(24'd1, 5'd8, 8'd1);
		pending_values.push_back(32'h1);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'h100);
		wait_idle();

		// zero guess taken as one; zero cap makes no step
		set_config(24'd0, 5'd8, 8'd0);
		pending_values.push_back(32'h100);
		pending_values.push_back(32'h0);
		wait_idle();
		set_config(24'd0, 5'd8, 8'd5);
		pending_values.push_back(32'h1000);
		pending_values.push_back(32'hFFFF_FFFF);
		wait_idle();

		set_config(24'($urandom_range(1, 24'hFF_FFFF)), 5'd8, 8'd10);
		run_phase(250, 0, 0);
		set_config(24'd1, 5'd10, 8'd14);
		run_phase(250, 50, 0);
		set_config(24'hFF_FFFF, 5'd12, 8'd16);
		run_phase(250, 0, 50);
		set_config(24'($urandom_range(1, 24'hFF_FFFF)), 5'd9, 8'd6);
		run_phase(250, 9, 9);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_roots.size() == 0) begin
			$display("newton_cube_root_unit verification clean");
		end else begin
			$display("newton_cube_root_unit verification failed");
		end
		$finish;
	end

endmodule
